// ===== sv/assert_macros.svh =====
// assertion shorthands used by the checker file
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is applied
`define DACR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is applied
`define DACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dacr_pkg.sv =====
// shared types and fixed constants for the control ramp block
// no dependencies; used by the top level and its checker
package dacr_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_INPUT_MODE       = 3'd0,
    REG_GAMEPAD_PRESENT  = 3'd1,
    REG_STEER_STEP       = 3'd2,
    REG_PEDAL_STEP       = 3'd3,
    REG_FIX_STEERING_BUG = 3'd4
  } reg_idx_t;

  // input_mode codes; the unused code behaves like analog wheel with digital pedals
  typedef enum logic [1:0] {
    MODE_DIGITAL      = 2'd0,
    MODE_ANALOG       = 2'd1,
    MODE_ANALOG_WHEEL = 2'd2
  } input_mode_t;

  // scaling constants (fixed by the scaling formulas)
  localparam logic [7:0]  STEER_ZERO   = 8'h80;
  localparam logic [7:0]  STEER_SAT_M  = 8'd56;     // |pos - centre| giving 128 or more
  localparam logic [19:0] STEER_RECIP  = 20'd9363;  // ceil(2^16 / 7)
  localparam int          STEER_SHIFT  = 12;        // 16 less the x16 pre-scale
  localparam logic [6:0]  STEER_LIMIT  = 7'h7F;
  localparam logic [7:0]  PEDAL_ZERO   = 8'h30;
  localparam logic [7:0]  PEDAL_SAT_M  = 8'h61;     // pedal span giving 256 or more
  localparam logic [23:0] PEDAL_RECIP  = 24'd43241; // ceil(2^22 / 97)
  localparam int          PEDAL_SHIFT  = 14;        // 22 less the x256 pre-scale
  localparam logic [7:0]  PEDAL_FULL   = 8'hFF;
  localparam logic signed [9:0] ACCUM_THRESH = 10'sd2;

  // input request, last field in the lowest bits
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] crash_hold_load;
    logic       crash_active;
    logic [7:0] brake_analog;
    logic [7:0] accel_analog;
    logic [7:0] wheel_analog;
    logic       brake_pressed;
    logic       accel_pressed;
    logic       right_pressed;
    logic       left_pressed;
  } in_item_t;

  // result request, last field in the lowest bits
  typedef struct packed {
    logic [7:0]        brake_scaled;
    logic [7:0]        accel_scaled;
    logic signed [7:0] steer_scaled;
    logic [7:0]        brake_raw;
    logic [7:0]        accel_raw;
    logic [7:0]        steer_raw;
  } out_item_t;

endpackage

// ===== sv/digital_to_analog_control_ramp_top.sv =====
// control ramp: buttons or analog readings to steering and pedal positions
// depends on dacr_pkg; checked by dacr_checker (bound in its own file)
//
//  channel | ports                               | moves
//  --------+-------------------------------------+---------------------------------
//  input   | in_tvalid in_tready in_tdata[39:0]  | one frame tick request
//  result  | out_tvalid out_tready out_tdata[47:0] | positions and scaled values
//  config  | cfg_psel cfg_penable cfg_pwrite ... | five registers at 4*index
//
// one request per cycle sustained while out_tready is high; a request passes the input
// register, then the ramp/scale logic into the result register
// the state loop is the single ramp, clamp and scale pass feeding the result register
// rst_n is synchronous: positions return to centre/zero, registers to defaults
// a stalled result holds in the result register while the input register still
// takes a request; both stall only once both are full
module digital_to_analog_control_ramp_top
  import dacr_pkg::*;
#(
  parameter int STEER_MIN    = 72,
  parameter int STEER_MAX    = 184,
  parameter int STEER_CENTRE = 128,
  parameter int PEDAL_LO     = 48,
  parameter int PEDAL_HI     = 144
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  // left_pressed, right_pressed, accel_pressed, brake_pressed, wheel_analog[7:0],
  // accel_analog[7:0], brake_analog[7:0], crash_active, crash_hold_load[7:0], 3 zero bits
  input  logic [39:0]       in_tdata,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  // steer_raw, accel_raw, brake_raw, steer_scaled (signed), accel_scaled, brake_scaled
  output logic [47:0]       out_tdata,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic signed [9:0] SMIN_W = 10'(STEER_MIN);
  localparam logic signed [9:0] SMAX_W = 10'(STEER_MAX);
  localparam logic signed [9:0] SCEN_W = 10'(STEER_CENTRE);
  localparam logic [7:0]        SCEN_8 = 8'(STEER_CENTRE);
  localparam logic [7:0]        PMIN_8 = 8'(PEDAL_LO);
  localparam logic [7:0]        PMAX_8 = 8'(PEDAL_HI);

  // configuration registers
  logic [1:0] mode_r;
  logic       pad_r;
  logic [6:0] steer_step_r;
  logic [7:0] pedal_step_r;
  logic       fix_r;

  // frame state
  logic [7:0]        steer_pos_r,    steer_pos_nxt;
  logic [7:0]        steer_prev_r,   steer_prev_nxt;
  logic signed [9:0] steer_accum_r,  steer_accum_nxt;
  logic [7:0]        accel_pos_r,    accel_pos_nxt;
  logic [7:0]        brake_pos_r,    brake_pos_nxt;
  logic signed [7:0] steer_scaled_r, steer_scaled_nxt;
  logic [7:0]        crash_hold_r,   crash_hold_nxt;

  // pipeline
  logic      a_valid_r;
  in_item_t  a_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      out_free;
  logic      a_fire;

  logic              digital_all;
  logic              analog_pedals;
  logic signed [9:0] ramp_w;
  logic signed [9:0] pre_w;
  logic signed [9:0] clamp_w;
  logic [7:0]        hold_cur;
  logic signed [9:0] acc_sum;
  logic              refresh;
  logic              cfg_wr;

  // pedal ramp with saturation at both ends
  function automatic logic [7:0] ramp_pedal(input logic [7:0] pos, input logic pressed,
                                            input logic [7:0] step);
    logic [8:0] sum;
    logic [8:0] dif;
    sum = {1'b0, pos} + {1'b0, step};
    dif = {1'b0, pos} - {1'b0, step};
    if (pressed) begin
      ramp_pedal = sum[8] ? PEDAL_FULL : sum[7:0];
    end else begin
      ramp_pedal = dif[8] ? 8'h00 : dif[7:0];
    end
  endfunction

  // (pos - 0x80) * 0x100 / 0x70, toward zero, limited to +-0x7F
  function automatic logic signed [7:0] scale_steer(input logic [7:0] pos);
    logic        neg;
    logic [7:0]  m;
    logic [19:0] prod;
    logic [7:0]  q;
    neg  = pos < STEER_ZERO;
    m    = neg ? (STEER_ZERO - pos) : (pos - STEER_ZERO);
    prod = 20'(m) * STEER_RECIP;
    q    = (m >= STEER_SAT_M) ? {1'b0, STEER_LIMIT} : prod[STEER_SHIFT +: 8];
    scale_steer = neg ? -signed'(q) : signed'(q);
  endfunction

  // clamp to the pedal range, then (p - 0x30) * 0x100 / 0x61 saturated to 0..255
  function automatic logic [7:0] scale_pedal(input logic [7:0] pos);
    logic [7:0]  p;
    logic [7:0]  m;
    logic [23:0] prod;
    if (pos > PMAX_8) begin
      p = PMAX_8;
    end else if (pos < PMIN_8) begin
      p = PMIN_8;
    end else begin
      p = pos;
    end
    m    = p - PEDAL_ZERO;
    prod = 24'(m) * PEDAL_RECIP;
    if (p < PEDAL_ZERO) begin
      scale_pedal = 8'h00;
    end else if (m >= PEDAL_SAT_M) begin
      scale_pedal = PEDAL_FULL;
    end else begin
      scale_pedal = prod[PEDAL_SHIFT +: 8];
    end
  endfunction

  // handshake: the input register drains whenever the result register can take it
  assign out_free   = !out_valid_r || out_tready;
  assign a_fire     = a_valid_r && out_free;
  assign in_tready  = !a_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_item_r <= in_item_t'(in_tdata);
    end
    if (a_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  // mode decode: no pad means everything digital
  assign digital_all   = (mode_r == MODE_DIGITAL) || !pad_r;
  assign analog_pedals = !digital_all && (mode_r == MODE_ANALOG);

  // steering ramp, computed wide; snaps to centre on reversal, drifts back when released
  always_comb begin
    logic signed [9:0] pos_w;
    logic signed [9:0] step_w;
    logic signed [9:0] base_w;
    pos_w  = signed'({2'b00, steer_pos_r});
    step_w = signed'({3'b000, steer_step_r});
    base_w = pos_w;
    ramp_w = pos_w;
    if (a_item_r.left_pressed) begin
      base_w = (pos_w > SCEN_W) ? SCEN_W : pos_w;
      ramp_w = base_w - step_w;
      if (ramp_w < SMIN_W) ramp_w = SMIN_W;
    end else if (a_item_r.right_pressed) begin
      base_w = (pos_w < SCEN_W) ? SCEN_W : pos_w;
      ramp_w = base_w + step_w;
      if (ramp_w > SMAX_W) ramp_w = SMAX_W;
    end else if (pos_w < SCEN_W) begin
      ramp_w = pos_w + step_w;
      if (ramp_w > SCEN_W) ramp_w = SCEN_W;
    end else if (pos_w > SCEN_W) begin
      ramp_w = pos_w - step_w;
      if (ramp_w < SCEN_W) ramp_w = SCEN_W;
    end
  end

  // position select and final steering clamp
  always_comb begin
    pre_w = digital_all ? ramp_w : signed'({2'b00, a_item_r.wheel_analog});
    if (pre_w < SMIN_W) begin
      clamp_w = SMIN_W;
    end else if (pre_w > SMAX_W) begin
      clamp_w = SMAX_W;
    end else begin
      clamp_w = pre_w;
    end
    steer_pos_nxt = clamp_w[7:0];
    if (analog_pedals) begin
      accel_pos_nxt = a_item_r.accel_analog;
      brake_pos_nxt = a_item_r.brake_analog;
    end else begin
      accel_pos_nxt = ramp_pedal(accel_pos_r, a_item_r.accel_pressed, pedal_step_r);
      brake_pos_nxt = ramp_pedal(brake_pos_r, a_item_r.brake_pressed, pedal_step_r);
    end
  end

  // crash hold countdown and the change threshold on scaled steering
  always_comb begin
    hold_cur        = (a_item_r.crash_hold_load != 8'h00) ? a_item_r.crash_hold_load
                                                          : crash_hold_r;
    acc_sum         = steer_accum_r + (signed'({2'b00, steer_pos_nxt})
                                       - signed'({2'b00, steer_prev_r}));
    crash_hold_nxt  = hold_cur;
    steer_prev_nxt  = steer_prev_r;
    steer_accum_nxt = steer_accum_r;
    refresh         = 1'b0;
    if (hold_cur != 8'h00) begin
      crash_hold_nxt = hold_cur - 8'd1;
      refresh        = 1'b1;
    end else begin
      steer_prev_nxt = steer_pos_nxt;
      if (fix_r || (acc_sum > ACCUM_THRESH) || (acc_sum < -ACCUM_THRESH)) begin
        steer_accum_nxt = '0;
        refresh         = 1'b1;
      end else begin
        steer_accum_nxt = acc_sum;
      end
    end
    if (!refresh) begin
      steer_scaled_nxt = steer_scaled_r;
    end else if (a_item_r.crash_active) begin
      steer_scaled_nxt = '0;
    end else begin
      steer_scaled_nxt = scale_steer(steer_pos_nxt);
    end
  end

  always_comb begin
    out_item_nxt.steer_raw    = steer_pos_nxt;
    out_item_nxt.accel_raw    = accel_pos_nxt;
    out_item_nxt.brake_raw    = brake_pos_nxt;
    out_item_nxt.steer_scaled = steer_scaled_nxt;
    out_item_nxt.accel_scaled = scale_pedal(accel_pos_nxt);
    out_item_nxt.brake_scaled = scale_pedal(brake_pos_nxt);
  end

  // frame state advances once per request leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_pos_r    <= SCEN_8;
      steer_prev_r   <= SCEN_8;
      steer_accum_r  <= '0;
      accel_pos_r    <= '0;
      brake_pos_r    <= '0;
      steer_scaled_r <= '0;
      crash_hold_r   <= '0;
    end else if (a_fire) begin
      steer_pos_r    <= steer_pos_nxt;
      steer_prev_r   <= steer_prev_nxt;
      steer_accum_r  <= steer_accum_nxt;
      accel_pos_r    <= accel_pos_nxt;
      brake_pos_r    <= brake_pos_nxt;
      steer_scaled_r <= steer_scaled_nxt;
      crash_hold_r   <= crash_hold_nxt;
    end
  end

  // configuration port: zero wait states, writes beyond the list are dropped
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DIGITAL;
      pad_r        <= 1'b0;
      steer_step_r <= 7'd8;
      pedal_step_r <= 8'd16;
      fix_r        <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_INPUT_MODE:       mode_r       <= cfg_pwdata[1:0];
        REG_GAMEPAD_PRESENT:  pad_r        <= cfg_pwdata[0];
        REG_STEER_STEP:       steer_step_r <= cfg_pwdata[6:0];
        REG_PEDAL_STEP:       pedal_step_r <= cfg_pwdata[7:0];
        REG_FIX_STEERING_BUG: fix_r        <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_INPUT_MODE:       cfg_prdata = {30'd0, mode_r};
      REG_GAMEPAD_PRESENT:  cfg_prdata = {31'd0, pad_r};
      REG_STEER_STEP:       cfg_prdata = {25'd0, steer_step_r};
      REG_PEDAL_STEP:       cfg_prdata = {24'd0, pedal_step_r};
      REG_FIX_STEERING_BUG: cfg_prdata = {31'd0, fix_r};
      default:              cfg_prdata = '0;
    endcase
  end

endmodule

// ===== sv/dacr_checker.sv =====
// port-level checks for the control ramp block, with the bind that attaches them
// depends on dacr_pkg and assert_macros.svh
`include "assert_macros.svh"

module dacr_checker
  import dacr_pkg::*;
#(
  parameter int STEER_MIN = 72,
  parameter int STEER_MAX = 184
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  localparam logic [7:0] SMIN_8 = 8'(STEER_MIN);
  localparam logic [7:0] SMAX_8 = 8'(STEER_MAX);

  out_item_t mon;
  assign mon = out_item_t'(out_tdata);

  // a stalled result stays put
  `DACR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  // an empty result register never back-pressures the input
  `DACR_ASSERT_IMPLIES(a_no_stall, !out_tvalid, in_tready, "input stalled with result register empty")
  // steering stays inside its travel
  `DACR_ASSERT_IMPLIES(a_steer_range, out_tvalid, (mon.steer_raw >= SMIN_8) && (mon.steer_raw <= SMAX_8), "steer_raw outside travel")
  // scaled steering is symmetric, never the most negative code
  `DACR_ASSERT_IMPLIES(a_steer_sym, out_tvalid, mon.steer_scaled != 8'sh80, "steer_scaled out of range")
  // both pedals share one scaling curve
  `DACR_ASSERT_IMPLIES(a_pedal_curve, out_tvalid && (mon.accel_raw == mon.brake_raw), mon.accel_scaled == mon.brake_scaled, "pedal scaling mismatch")

endmodule

bind digital_to_analog_control_ramp_top dacr_checker #(
  .STEER_MIN(STEER_MIN),
  .STEER_MAX(STEER_MAX)
) u_dacr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for digital_to_analog_control_ramp_top
// uses dacr_pkg for the request layouts and register indexes; needs only the rtl
// a predictor tracks ramp and scale state per accepted request and checks each result
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dacr_pkg::*;

  // block parameters, passed to the instance so that both sides agree
  localparam int STEER_MIN    = 72;
  localparam int STEER_MAX    = 184;
  localparam int STEER_CENTRE = 128;
  localparam int PEDAL_LO     = 48;
  localparam int PEDAL_HI     = 144;

  localparam int SPARE_REG_IDX  = 5;    // first index past the register list
  localparam int SETTLE_CYCLES  = 4;    // margin after the last result
  localparam int LONG_HOLD      = 60;   // receiver hold-off, well past the two-deep buffering
  localparam int WATCHDOG_LIMIT = 5000; // cycles without any accepted request
  localparam int MAX_GAP        = 20;

  // predictor: own copy of the registers and ramp state, plus the queue of
  // results still owed by the block
  class ramp_tracker;
    logic [1:0] mode;
    bit         gamepad;
    int         steer_step;
    int         pedal_step;
    bit         fix_bug;

    int steer_pos;
    int steer_prev;
    int steer_accum;
    int accel_pos;
    int brake_pos;
    int steer_scaled_q;
    int crash_hold;

    out_item_t expected_results[$];
    int        bad_results;

    function new();
      mode           = MODE_DIGITAL;
      gamepad        = 1'b0;
      steer_step     = 8;
      pedal_step     = 16;
      fix_bug        = 1'b0;
      steer_pos      = STEER_CENTRE;
      steer_prev     = STEER_CENTRE;
      steer_accum    = 0;
      accel_pos      = 0;
      brake_pos      = 0;
      steer_scaled_q = 0;
      crash_hold     = 0;
      bad_results    = 0;
    endfunction

    function void set_register(int idx, int unsigned value);
      case (idx)
        REG_INPUT_MODE:       mode       = value[1:0];
        REG_GAMEPAD_PRESENT:  gamepad    = value[0];
        REG_STEER_STEP:       steer_step = int'(value[6:0]);
        REG_PEDAL_STEP:       pedal_step = int'(value[7:0]);
        REG_FIX_STEERING_BUG: fix_bug    = value[0];
        default: ;
      endcase
    endfunction

    function void ramp_steer(bit left, bit right);
      if (left) begin
        // reversal snaps to centre first
        if (steer_pos > STEER_CENTRE) steer_pos = STEER_CENTRE;
        steer_pos -= steer_step;
        if (steer_pos < STEER_MIN) steer_pos = STEER_MIN;
      end else if (right) begin
        if (steer_pos < STEER_CENTRE) steer_pos = STEER_CENTRE;
        steer_pos += steer_step;
        if (steer_pos > STEER_MAX) steer_pos = STEER_MAX;
      end else if (steer_pos < STEER_CENTRE) begin
        steer_pos += steer_step;
        if (steer_pos > STEER_CENTRE) steer_pos = STEER_CENTRE;
      end else if (steer_pos > STEER_CENTRE) begin
        steer_pos -= steer_step;
        if (steer_pos < STEER_CENTRE) steer_pos = STEER_CENTRE;
      end
    endfunction

    function int ramp_pedal(int pos, bit pressed);
      if (pressed) begin
        pos += pedal_step;
        if (pos > 255) pos = 255;
      end else begin
        pos -= pedal_step;
        if (pos < 0) pos = 0;
      end
      return pos;
    endfunction

    function int steer_scale();
      int d;
      d = ((steer_pos - int'(STEER_ZERO)) * 256) / 112;
      if (d > int'(STEER_LIMIT)) d = int'(STEER_LIMIT);
      else if (d < -int'(STEER_LIMIT)) d = -int'(STEER_LIMIT);
      return d;
    endfunction

    function logic [7:0] pedal_scale(int p);
      int d;
      if (p > PEDAL_HI) p = PEDAL_HI;
      else if (p < PEDAL_LO) p = PEDAL_LO;
      d = ((p - int'(PEDAL_ZERO)) * 256) / 97;
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      return 8'(d);
    endfunction

    function void note_request(in_item_t t);
      out_item_t r;
      int        mag;
      if (t.crash_hold_load != 8'd0) crash_hold = int'(t.crash_hold_load);
      if (mode == MODE_DIGITAL || !gamepad) begin
        ramp_steer(t.left_pressed, t.right_pressed);
        accel_pos = ramp_pedal(accel_pos, t.accel_pressed);
        brake_pos = ramp_pedal(brake_pos, t.brake_pressed);
      end else begin
        steer_pos = int'(t.wheel_analog);
        if (mode == MODE_ANALOG) begin
          accel_pos = int'(t.accel_analog);
          brake_pos = int'(t.brake_analog);
        end else begin
          // analog wheel with digital pedals, unused code included
          accel_pos = ramp_pedal(accel_pos, t.accel_pressed);
          brake_pos = ramp_pedal(brake_pos, t.brake_pressed);
        end
      end
      if (steer_pos < STEER_MIN) steer_pos = STEER_MIN;
      else if (steer_pos > STEER_MAX) steer_pos = STEER_MAX;

      if (crash_hold != 0) begin
        // crash hold refreshes every tick and leaves the change tracking alone
        crash_hold--;
        steer_scaled_q = t.crash_active ? 0 : steer_scale();
      end else begin
        steer_accum += steer_pos - steer_prev;
        steer_prev = steer_pos;
        mag = (steer_accum < 0) ? -steer_accum : steer_accum;
        if (fix_bug || mag > int'(ACCUM_THRESH)) begin
          steer_accum = 0;
          steer_scaled_q = t.crash_active ? 0 : steer_scale();
        end
      end

      r.steer_raw    = 8'(steer_pos);
      r.accel_raw    = 8'(accel_pos);
      r.brake_raw    = 8'(brake_pos);
      r.steer_scaled = 8'(steer_scaled_q);
      r.accel_scaled = pedal_scale(accel_pos);
      r.brake_scaled = pedal_scale(brake_pos);
      expected_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        if (bad_results < 10)
          $display("result with nothing outstanding: %h", got);
        bad_results++;
        return;
      end
      want = expected_results.pop_front();
      if (got.steer_raw !== want.steer_raw || got.accel_raw !== want.accel_raw ||
          got.brake_raw !== want.brake_raw || got.steer_scaled !== want.steer_scaled ||
          got.accel_scaled !== want.accel_scaled ||
          got.brake_scaled !== want.brake_scaled) begin
        if (bad_results < 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected raw %0d %0d %0d scaled %0d %0d %0d", want.steer_raw,
                   want.accel_raw, want.brake_raw, $signed(want.steer_scaled),
                   want.accel_scaled, want.brake_scaled);
          $display("  actual   raw %0d %0d %0d scaled %0d %0d %0d", got.steer_raw,
                   got.accel_raw, got.brake_raw, $signed(got.steer_scaled),
                   got.accel_scaled, got.brake_scaled);
        end
        bad_results++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // one random run: register settings, idling percentages, length and the long hold flag
  typedef struct {
    int mode;
    int gamepad;
    int sstep;
    int pstep;
    int fix;
    int idle_pct;
    int stall_pct;
    int count;
    bit long_hold;
  } phase_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [47:0]       out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  ramp_tracker tracker = new();

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_req = 1'b0;
  int         quiet_cycles = 0;
  logic [3:0] buttons = '0;
  logic [7:0] wheel_last = 8'h80;
  phase_t     plan[8];

  always #1 clk = ~clk;

  digital_to_analog_control_ramp_top #(
    .STEER_MIN   (STEER_MIN),
    .STEER_MAX   (STEER_MAX),
    .STEER_CENTRE(STEER_CENTRE),
    .PEDAL_LO    (PEDAL_LO),
    .PEDAL_HI    (PEDAL_HI)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // result side: every accepted result goes straight to the predictor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_item_t'(out_tdata));
  end

  // receiver ready: random stalls, or one long hold-off when asked so that
  // both internal registers fill and the input side backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: any accepted request on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("digital_to_analog_control_ramp_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register write: setup cycle, then access until pready
  task automatic cfg_write(int idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx * 4);
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(int mode, int gamepad, int sstep, int pstep, int fix);
    cfg_write(REG_INPUT_MODE, mode);
    cfg_write(REG_GAMEPAD_PRESENT, gamepad);
    cfg_write(REG_STEER_STEP, sstep);
    cfg_write(REG_PEDAL_STEP, pstep);
    cfg_write(REG_FIX_STEERING_BUG, fix);
  endtask

  // offer one tick request, hold it until taken, then maybe go idle a while;
  // valid is only lowered when a gap follows, so it never toggles in one step
  task automatic send_tick(in_item_t t);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(t);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // close a stretch of requests: stop offering, let every result arrive
  // and let the pipeline settle before registers change
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t tick(bit l, bit r, bit a, bit b, int wheel, int acc,
                                    int brk, bit crash, int load);
    in_item_t t;
    t = '0;
    t.left_pressed    = l;
    t.right_pressed   = r;
    t.accel_pressed   = a;
    t.brake_pressed   = b;
    t.wheel_analog    = 8'(wheel);
    t.accel_analog    = 8'(acc);
    t.brake_analog    = 8'(brk);
    t.crash_active    = crash;
    t.crash_hold_load = 8'(load);
    return t;
  endfunction

  // buttons are held for runs so the ramps reach their limits; the wheel
  // sometimes creeps by a step or two to sit near the change threshold
  function automatic in_item_t random_tick();
    in_item_t t;
    int       roll;
    t = '0;
    if ($urandom_range(5) == 0) buttons = 4'($urandom_range(15));
    {t.brake_pressed, t.accel_pressed, t.right_pressed, t.left_pressed} = buttons;
    case ($urandom_range(3))
      0: wheel_last = 8'($urandom_range(255));
      1: wheel_last = wheel_last + 8'($urandom_range(4)) - 8'd2;
      2: wheel_last = $urandom_range(1) ? 8'hFF : 8'h00;
      default: wheel_last = 8'($urandom_range(STEER_MAX + 8, STEER_MIN - 8));
    endcase
    t.wheel_analog = wheel_last;
    t.accel_analog = 8'($urandom_range(255));
    t.brake_analog = 8'($urandom_range(255));
    t.crash_active = ($urandom_range(4) == 0);
    roll = $urandom_range(99);
    if (roll < 5) t.crash_hold_load = 8'($urandom_range(12, 1));
    else if (roll == 5) t.crash_hold_load = 8'($urandom_range(255, 1));
    return t;
  endfunction

  initial begin
    plan[0] = '{0, 0,  8,  16, 0,  0,  0, 90, 1'b0};
    plan[1] = '{1, 1,  8,  16, 0, 45,  0, 90, 1'b0};
    plan[2] = '{2, 1, 64, 255, 1,  0, 45, 90, 1'b0};
    plan[3] = '{0, 1,  0,   0, 0, 31, 31, 80, 1'b0};
    plan[4] = '{3, 1,  1,   1, 0,  0,  0, 80, 1'b1};
    plan[5] = '{1, 0, 33, 200, 1, 45, 45, 90, 1'b0};
    plan[6] = '{2, 1,  5,   7, 0, 31, 31, 90, 1'b0};
    plan[7] = '{1, 1, 64,   0, 1, 45,  0, 90, 1'b0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // digital controls with a steer step of 64 and the largest pedal step
    cfg_write(REG_STEER_STEP, 64);
    cfg_write(REG_PEDAL_STEP, 255);
    send_tick(tick(0, 1, 0, 0, 0, 0, 0, 0, 0));       // right, overshoot clamps at max
    send_tick(tick(0, 1, 0, 0, 255, 255, 255, 0, 0)); // stays at max
    send_tick(tick(1, 0, 0, 0, 0, 0, 0, 0, 0));       // reversal snaps to centre, clamps at min
    send_tick(tick(1, 1, 0, 0, 0, 0, 0, 0, 0));       // both held, left wins
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0));       // released, back to centre
    send_tick(tick(0, 0, 1, 1, 0, 0, 0, 0, 0));       // pedals saturate high
    send_tick(tick(0, 0, 1, 0, 0, 0, 0, 0, 0));       // accel held at top, brake falls
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0));       // pedals saturate at zero
    send_tick(tick(0, 1, 0, 0, 0, 0, 0, 1, 3));       // crash hold loaded, crash forces zero
    send_tick(tick(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0));       // last held tick, scale refreshed
    send_tick(tick(0, 1, 0, 0, 0, 0, 0, 0, 255));     // longest hold
    settle();

    // analog wheel and pedals: extremes, slow wheel creep, pedal range edges
    cfg_all(MODE_ANALOG, 1, 8, 16, 0);
    send_tick(tick(0, 0, 0, 0, 0, 0, 255, 0, 0));
    send_tick(tick(1, 1, 1, 1, 255, 255, 0, 0, 0));
    send_tick(tick(0, 0, 0, 0, 128, 48, 144, 0, 0));
    send_tick(tick(0, 0, 0, 0, 129, 47, 145, 0, 0));
    send_tick(tick(0, 0, 0, 0, 130, 49, 143, 0, 0));
    send_tick(tick(0, 0, 0, 0, 131, 97, 96, 0, 0));   // still inside the long crash hold
    send_tick(tick(0, 0, 0, 0, 73, 0, 0, 1, 0));
    settle();

    // unused mode code behaves as analog wheel with digital pedals; a write
    // past the register list must change nothing
    cfg_all(3, 1, 1, 1, 0);
    cfg_write(SPARE_REG_IDX, 32'hFFFF_FFFF);
    send_tick(tick(0, 0, 1, 0, 200, 0, 0, 0, 0));
    send_tick(tick(0, 0, 0, 1, 50, 255, 255, 0, 0));
    send_tick(tick(0, 0, 0, 0, 184, 0, 0, 0, 0));
    settle();

    // random phases across settings and idling patterns
    foreach (plan[p]) begin
      cfg_all(plan[p].mode, plan[p].gamepad, plan[p].sstep, plan[p].pstep, plan[p].fix);
      send_idle_pct  = plan[p].idle_pct;
      recv_stall_pct = plan[p].stall_pct;
      if (plan[p].long_hold) hold_req = 1'b1;
      repeat (plan[p].count) send_tick(random_tick());
      settle();
    end

    if (tracker.bad_results == 0 && tracker.pending() == 0) begin
      $display("digital_to_analog_control_ramp_top verification clean");
    end else begin
      $display("digital_to_analog_control_ramp_top verification failed");
    end
    $finish;
  end

endmodule

// ===== digital_to_analog_control_ramp_top.f =====
+incdir+sv
sv/dacr_pkg.sv
sv/digital_to_analog_control_ramp_top.sv
sv/dacr_checker.sv
tb/sv/testbench.sv
